>>> design/rpt_pkg.sv
`timescale 1ns / 1ps
package rpt_pkg;
  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_POLL = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  localparam int unsigned RegTimeout = 0;
  localparam int unsigned RegRetries = 1;
  localparam logic [15:0] TimeoutReset = 16'd250;
  localparam logic [7:0]  RetriesReset = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_WB,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [7:0]  retries;
  } entry_t;

  typedef struct packed {
    logic        table_full;
    logic [4:0]  removed_count;
    logic        expired_found;
    logic [15:0] expired_seq;
    logic        final_retry;
    logic [31:0] retransmit_total;
  } result_t;
endpackage

>>> design/rpt_if.sv
`timescale 1ns / 1ps
interface rpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] seq;
  logic [15:0] ack_min;
  logic [15:0] ack_max;
  logic [31:0] now_ms;
  modport source (output valid, kind, seq, ack_min, ack_max, now_ms, input ready);
  modport sink (input valid, kind, seq, ack_min, ack_max, now_ms, output ready);
endinterface

interface rpt_out_if;
  logic        valid;
  logic        ready;
  logic        table_full;
  logic [4:0]  removed_count;
  logic        expired_found;
  logic [15:0] expired_seq;
  logic        final_retry;
  logic [31:0] retransmit_total;
  modport source (output valid, table_full, removed_count, expired_found, expired_seq,
                  final_retry, retransmit_total, input ready);
  modport sink (input valid, table_full, removed_count, expired_found, expired_seq,
                final_retry, retransmit_total, output ready);
endinterface

interface rpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/rpt_ram.sv
`timescale 1ns / 1ps
module rpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/rpt_order.sv
`timescale 1ns / 1ps
// Insertion-age bookkeeping: valid bits and arrival ranks per slot, one row
// of cells. Ranks compact when an entry is dropped.
module rpt_order #(
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     add_i,
  input  logic [$clog2(Depth)-1:0] add_idx_i,
  input  logic                     drop_i,
  input  logic [$clog2(Depth)-1:0] drop_idx_i,
  output logic [Depth-1:0]         valid_o,
  output logic [$clog2(Depth)-1:0] free_idx_o,
  output logic                     has_free_o,
  input  logic [$clog2(Depth)-1:0] rank_idx_i,
  output logic [$clog2(Depth):0]   rank_o
);
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned RankW = IdxW + 1;

  logic [Depth-1:0] valid_q;
  logic [RankW-1:0] rank_q [Depth];
  logic [RankW-1:0] count_q;
  logic [RankW-1:0] drop_rank;

  assign valid_o = valid_q;
  assign drop_rank = rank_q[drop_idx_i];
  assign rank_o = rank_q[rank_idx_i];

  always_comb begin
    free_idx_o = '0;
    has_free_o = 1'b0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx_o = IdxW'(i);
        has_free_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (add_i) begin
      valid_q[add_idx_i] <= 1'b1;
      count_q <= count_q + 1'b1;
    end else if (drop_i) begin
      valid_q[drop_idx_i] <= 1'b0;
      count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (add_i && add_idx_i == IdxW'(i)) begin
        rank_q[i] <= count_q;
      end else if (drop_i && valid_q[i] && rank_q[i] > drop_rank) begin
        rank_q[i] <= rank_q[i] - 1'b1;
      end
    end
  end
endmodule

>>> design/retransmit_pending_table.sv
`timescale 1ns / 1ps
// Pending-packet table for retransmission.
// Channels: in_if (add, ack range, poll), out_if (one result per item),
// cfg_if (register 0 resend timeout, register 1 retry limit).
// Entry payload (seq, stamp, retries) lives in one RAM with a registered read;
// valid bits and insertion ranks sit in flip-flops.
// Add: the result passes ST_RD and ST_OUT before it is valid. Ack and poll scan
// the RAM one entry a cycle; an ack drops each match as it passes, a poll
// restamps the oldest expired entry and bumps its retries with one write-back,
// dropping it once the retry limit is reached.
// One item at a time; in_if is ready again in the cycle after the result
// transfer.
// Reset clears valid bits, rank count and total and sets the config registers to their defaults; no RAM sweep.
// A stalled output holds its result; the next item waits for the transfer.
module retransmit_pending_table #(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  rpt_in_if.sink    in_if,
  rpt_out_if.source out_if,
  rpt_cfg_if.sink   cfg_if
);
  localparam int unsigned IdxW = $clog2(PENDING_DEPTH);
  localparam int unsigned CntW = IdxW + 1;

  rpt_pkg::state_e state_q, state_d;
  logic [15:0] timeout_q;
  logic [7:0]  retries_max_q;
  logic [31:0] total_q;
  logic [1:0]  kind_q;
  logic [15:0] seq_q, amin_q, amax_q;
  logic [31:0] now_q;
  logic [CntW-1:0] ptr_q;       // address issued
  logic [IdxW-1:0] cur_q;       // index of the data now on rdata
  logic            cur_v_q;
  logic [4:0]  removed_q;
  logic        have_q;
  logic [IdxW-1:0] best_q;
  logic [CntW-1:0] best_rank_q;
  rpt_pkg::entry_t best_e_q;
  rpt_pkg::result_t res_q;
  logic out_v_q, full_q, fin_q;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  rpt_pkg::entry_t wdata, rdata;
  logic add, drop;
  logic [IdxW-1:0] drop_idx, free_idx;
  logic [PENDING_DEPTH-1:0] valid;
  logic has_free;
  logic [CntW-1:0] rank;
  logic hit_ack, hit_exp;
  logic [31:0] elapsed;
  logic [7:0] new_ret;

  rpt_ram #(.Width($bits(rpt_pkg::entry_t)), .Depth(PENDING_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  rpt_order #(.Depth(PENDING_DEPTH)) u_order (
    .clk_i, .rst_ni, .add_i(add), .add_idx_i(free_idx), .drop_i(drop), .drop_idx_i(drop_idx),
    .valid_o(valid), .free_idx_o(free_idx), .has_free_o(has_free),
    .rank_idx_i(cur_q), .rank_o(rank)
  );

  assign in_if.ready = (state_q == rpt_pkg::ST_IDLE) && !out_v_q;
  assign cfg_if.ready = 1'b1;
  assign raddr = ptr_q[IdxW-1:0];
  assign elapsed = now_q - rdata.stamp;
  assign hit_ack = cur_v_q && valid[cur_q] && rdata.seq >= amin_q && rdata.seq <= amax_q;
  assign hit_exp = cur_v_q && valid[cur_q] && elapsed >= {16'd0, timeout_q};
  assign new_ret = (best_e_q.retries == 8'hFF) ? 8'hFF : best_e_q.retries + 8'd1;

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = best_q;
    wdata = '{seq: seq_q, stamp: now_q, retries: new_ret};
    add = 1'b0;
    drop = 1'b0;
    drop_idx = cur_q;
    unique case (state_q)
      rpt_pkg::ST_IDLE: if (in_if.valid && in_if.ready) state_d = rpt_pkg::ST_RD;
      rpt_pkg::ST_RD: begin
        unique case (kind_q)
          rpt_pkg::KIND_ADD: begin
            if (has_free) begin
              we = 1'b1;
              waddr = free_idx;
              wdata = '{seq: seq_q, stamp: now_q, retries: 8'd0};
              add = 1'b1;
            end
            state_d = rpt_pkg::ST_OUT;
          end
          rpt_pkg::KIND_ACK, rpt_pkg::KIND_POLL: state_d = rpt_pkg::ST_SCAN;
          default: state_d = rpt_pkg::ST_OUT;
        endcase
      end
      rpt_pkg::ST_SCAN: begin
        if (kind_q == rpt_pkg::KIND_ACK && hit_ack) drop = 1'b1;
        if (!cur_v_q && ptr_q == CntW'(PENDING_DEPTH)) begin
          state_d = (kind_q == rpt_pkg::KIND_POLL) ? rpt_pkg::ST_WB : rpt_pkg::ST_OUT;
        end
      end
      rpt_pkg::ST_WB: begin
        if (have_q) begin
          we = 1'b1;
          wdata = '{seq: best_e_q.seq, stamp: now_q, retries: new_ret};
          drop = new_ret >= retries_max_q;
          drop_idx = best_q;
        end
        state_d = rpt_pkg::ST_OUT;
      end
      rpt_pkg::ST_OUT: state_d = rpt_pkg::ST_IDLE;
      default: state_d = rpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpt_pkg::ST_IDLE;
      timeout_q <= rpt_pkg::TimeoutReset;
      retries_max_q <= rpt_pkg::RetriesReset;
      total_q <= '0;
      out_v_q <= 1'b0;
      cur_v_q <= 1'b0;
      ptr_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_if.valid) begin
        if (cfg_if.index == 1'(rpt_pkg::RegTimeout)) timeout_q <= cfg_if.data[15:0];
        else retries_max_q <= cfg_if.data[7:0];
      end
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      if (state_q == rpt_pkg::ST_RD) begin
        // address 0 is read in this cycle
        ptr_q <= CntW'(1);
        cur_v_q <= 1'b1;
      end else if (state_q == rpt_pkg::ST_SCAN) begin
        cur_v_q <= ptr_q != CntW'(PENDING_DEPTH);
        if (ptr_q != CntW'(PENDING_DEPTH)) ptr_q <= ptr_q + 1'b1;
      end else begin
        ptr_q <= '0;
        cur_v_q <= 1'b0;
      end
      if (state_q == rpt_pkg::ST_WB && have_q) total_q <= total_q + 32'd1;
      if (state_q == rpt_pkg::ST_OUT) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      kind_q <= in_if.kind;
      seq_q <= in_if.seq;
      amin_q <= in_if.ack_min;
      amax_q <= in_if.ack_max;
      now_q <= in_if.now_ms;
      removed_q <= '0;
      have_q <= 1'b0;
      full_q <= 1'b0;
      fin_q <= 1'b0;
    end
    // data for address ptr arrives next cycle
    if (state_q == rpt_pkg::ST_RD) cur_q <= '0;
    else if (state_q == rpt_pkg::ST_SCAN) cur_q <= ptr_q[IdxW-1:0];
    if (state_q == rpt_pkg::ST_RD && kind_q == rpt_pkg::KIND_ADD) full_q <= !has_free;
    if (state_q == rpt_pkg::ST_SCAN && kind_q == rpt_pkg::KIND_ACK && hit_ack &&
        removed_q != 5'd31)
      removed_q <= removed_q + 5'd1;
    if (state_q == rpt_pkg::ST_SCAN && kind_q == rpt_pkg::KIND_POLL && hit_exp &&
        (!have_q || rank < best_rank_q)) begin
      have_q <= 1'b1;
      best_q <= cur_q;
      best_rank_q <= rank;
      best_e_q <= rdata;
    end
    if (state_q == rpt_pkg::ST_WB) fin_q <= have_q && (new_ret >= retries_max_q);
    if (state_q == rpt_pkg::ST_OUT) begin
      res_q.table_full <= full_q;
      res_q.removed_count <= removed_q;
      res_q.expired_found <= have_q;
      res_q.expired_seq <= have_q ? best_e_q.seq : 16'd0;
      res_q.final_retry <= fin_q;
      res_q.retransmit_total <= total_q;
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.table_full = res_q.table_full;
  assign out_if.removed_count = res_q.removed_count;
  assign out_if.expired_found = res_q.expired_found;
  assign out_if.expired_seq = res_q.expired_seq;
  assign out_if.final_retry = res_q.final_retry;
  assign out_if.retransmit_total = res_q.retransmit_total;
endmodule

>>> design/rpt_checker.sv
`timescale 1ns / 1ps
module rpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        table_full_i,
  input logic        expired_found_i,
  input logic        final_retry_i,
  input logic [4:0]  removed_count_i,
  input logic [31:0] total_i
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(total_i)) else $error("stall lost");
  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("accept while result pending");
  a_final_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && final_retry_i |-> expired_found_i) else $error("final without resend");
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(table_full_i && (expired_found_i || removed_count_i != 5'd0)))
    else $error("mixed result kinds");
endmodule

bind retransmit_pending_table rpt_checker u_rpt_checker (
  .clk_i, .rst_ni,
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .table_full_i(out_if.table_full), .expired_found_i(out_if.expired_found),
  .final_retry_i(out_if.final_retry), .removed_count_i(out_if.removed_count),
  .total_i(out_if.retransmit_total)
);

>>> tb/rpt_checker.sv
`timescale 1ns / 1ps
module rpt_tb_checker
  import rpt_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  rpt_in_if    in_if,
  rpt_out_if   out_if,
  rpt_cfg_if   cfg_if,
  output int   fail_count_o,
  output int   pending_o
);
  logic [15:0] resend_limit;
  logic [7:0]  retry_limit;
  logic        slot_used    [DEPTH];
  logic [15:0] slot_seq     [DEPTH];
  logic [31:0] slot_stamp   [DEPTH];
  logic [7:0]  slot_retries [DEPTH];
  logic [15:0] slot_rank    [DEPTH];
  logic [15:0] next_rank;
  logic [31:0] resend_total;
  result_t     expected_results_q[$];

  assign pending_o = expected_results_q.size();

  // free a slot and close the gap in insertion ranks
  function automatic void drop_slot(int idx);
    logic [15:0] rank;
    rank = slot_rank[idx];
    slot_used[idx] = 1'b0;
    for (int j = 0; j < DEPTH; j++) begin
      if (slot_used[j] && slot_rank[j] > rank) slot_rank[j] = slot_rank[j] - 16'd1;
    end
    if (next_rank > 0) next_rank = next_rank - 16'd1;
  endfunction

  function automatic result_t predict_result(kind_e kind, logic [15:0] seq,
                                             logic [15:0] amin, logic [15:0] amax,
                                             logic [31:0] now);
    result_t r;
    logic    placed;
    logic    have;
    int      best;
    r = '0;
    placed = 1'b0;
    have = 1'b0;
    best = 0;
    case (kind)
      KIND_ADD: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!placed && !slot_used[i]) begin
            slot_used[i]    = 1'b1;
            slot_seq[i]     = seq;
            slot_stamp[i]   = now;
            slot_retries[i] = '0;
            slot_rank[i]    = next_rank;
            next_rank       = next_rank + 16'd1;
            placed          = 1'b1;
          end
        end
        r.table_full = !placed;
      end
      KIND_ACK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && slot_seq[i] >= amin && slot_seq[i] <= amax) begin
            drop_slot(i);
            if (r.removed_count < 5'd31) r.removed_count = r.removed_count + 5'd1;
          end
        end
      end
      KIND_POLL: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && (now - slot_stamp[i]) >= {16'd0, resend_limit}) begin
            if (!have || slot_rank[i] < slot_rank[best]) begin
              best = i;
              have = 1'b1;
            end
          end
        end
        if (have) begin
          r.expired_found = 1'b1;
          r.expired_seq   = slot_seq[best];
          slot_stamp[best] = now;
          if (slot_retries[best] != 8'hFF) slot_retries[best] = slot_retries[best] + 8'd1;
          if (slot_retries[best] >= retry_limit) begin
            r.final_retry = 1'b1;
            drop_slot(best);
          end
          resend_total = resend_total + 32'd1;
        end
      end
      default: ;
    endcase
    r.retransmit_total = resend_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    result_t got;
    if (!rst_ni) begin
      resend_limit = TimeoutReset;
      retry_limit  = RetriesReset;
      next_rank    = '0;
      resend_total = '0;
      fail_count_o = 0;
      for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      expected_results_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.table_full       = out_if.table_full;
        got.removed_count    = out_if.removed_count;
        got.expired_found    = out_if.expired_found;
        got.expired_seq      = out_if.expired_seq;
        got.final_retry      = out_if.final_retry;
        got.retransmit_total = out_if.retransmit_total;
        if (expected_results_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_results_q.pop_front();
          if (got.table_full !== exp_r.table_full ||
              got.removed_count !== exp_r.removed_count ||
              got.expired_found !== exp_r.expired_found ||
              got.expired_seq !== exp_r.expired_seq ||
              got.final_retry !== exp_r.final_retry ||
              got.retransmit_total !== exp_r.retransmit_total) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == RegTimeout[0:0]) resend_limit = cfg_if.data[15:0];
        else retry_limit = cfg_if.data[7:0];
      end
      if (in_if.valid && in_if.ready)
        expected_results_q.push_back(predict_result(kind_e'(in_if.kind), in_if.seq,
                                                    in_if.ack_min, in_if.ack_max,
                                                    in_if.now_ms));
    end
  end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rpt_pkg::*;

  localparam int WatchLimit = 5000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  logic quiet;
  logic took_result = 1'b0;
  int   stall_left = 0;
  logic [31:0] clock_ms;
  logic [15:0] seq_base;
  logic [15:0] cur_timeout;

  rpt_in_if  in_if ();
  rpt_out_if out_if ();
  rpt_cfg_if cfg_if ();

  retransmit_pending_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  rpt_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_if       (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver: draw a stall after every result transfer
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) took_result = 1'b1;
  end

  always @(negedge clk_i) begin
    if (took_result) begin
      took_result = 1'b0;
      stall_left = quiet ? 0 : $urandom_range(0, 10);
    end
    if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("retransmit_pending_table verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(kind_e kind, logic [15:0] seq, logic [15:0] amin,
                           logic [15:0] amax, logic [31:0] now);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.kind    = kind;
    in_if.seq     = seq;
    in_if.ack_min = amin;
    in_if.ack_max = amax;
    in_if.now_ms  = now;
    in_if.valid   = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    if (idx == RegTimeout[0:0]) cur_timeout = data[15:0];
  endtask

  task automatic random_item();
    int          pick;
    logic [15:0] lo;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      // noise: every field unconstrained
      clock_ms = $urandom;
      send_item(kind_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                16'($urandom), clock_ms);
    end else if (pick < 40) begin
      clock_ms = clock_ms + $urandom_range(0, 20);
      send_item(KIND_ADD, seq_base + 16'($urandom_range(0, 40)), 16'($urandom),
                16'($urandom), clock_ms);
    end else if (pick < 60) begin
      lo = seq_base + 16'($urandom_range(0, 40));
      send_item(KIND_ACK, 16'($urandom), lo, lo + 16'($urandom_range(0, 12)), clock_ms);
    end else if (pick < 95) begin
      clock_ms = clock_ms + $urandom_range(0, 2 * cur_timeout + 30);
      send_item(KIND_POLL, 16'($urandom), 16'($urandom), 16'($urandom), clock_ms);
    end else begin
      send_item(KIND_NONE, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    end
    if ($urandom_range(0, 49) == 0) seq_base = 16'($urandom);
  endtask

  initial begin
    logic [15:0] timeouts [6];
    logic [7:0]  limits   [6];
    rst_ni = 1'b0;
    quiet = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_NONE;
    in_if.seq = '0;
    in_if.ack_min = '0;
    in_if.ack_max = '0;
    in_if.now_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    cur_timeout = TimeoutReset;
    timeouts = '{16'd0, 16'd65535, 16'd1, 16'd40, 16'd300, 16'd250};
    limits   = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd6, 8'd3};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: edge values, duplicates, wrapped time, empty range, full table
    send_item(KIND_ADD, 16'h0000, '0, '0, 32'hFFFF_FF00);
    send_item(KIND_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(KIND_ADD, 16'hFFFF, '0, '0, 32'h0000_0000);
    send_item(KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(KIND_POLL, '0, '0, '0, 32'h0000_0020);
    send_item(KIND_POLL, '0, '0, '0, 32'h0000_0120);
    send_item(KIND_ACK, '0, 16'd5, 16'd4, '0);
    send_item(KIND_ACK, '0, 16'h0000, 16'hFFFF, '0);
    for (int i = 0; i < 17; i++) send_item(KIND_ADD, 16'(i * 3), '0, '0, 32'(i));
    send_item(KIND_ACK, '0, 16'h0000, 16'hFFFF, '0);

    // retry count climbs to the largest limit on a single entry
    drain();
    write_reg(RegTimeout[0:0], 32'd0);
    write_reg(RegRetries[0:0], 32'd255);
    quiet = 1'b1;
    send_item(KIND_ADD, 16'h1234, '0, '0, 32'd7);
    for (int i = 0; i < 256; i++) send_item(KIND_POLL, '0, '0, '0, 32'(i));
    quiet = 1'b0;

    clock_ms = 32'hFFFF_F000;
    seq_base = 16'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(RegTimeout[0:0], {16'hABCD * 16'(ph), timeouts[ph]});
      write_reg(RegRetries[0:0], {24'h5A5A5A, limits[ph]});
      quiet = (ph == 3);
      for (int n = 0; n < 28; n++) begin
        random_item();
        if (n == 14) begin
          in_if.valid = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
      end
    end
    quiet = 1'b0;

    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("retransmit_pending_table verification clean");
    end else begin
      $display("retransmit_pending_table verification failed");
    end
    $finish;
  end
endmodule
